>>> sv/websocket_frame_deframer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the WebSocket deframer.
// Shared clocked implication checks with an active-low reset guard.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFD_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("deframer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define WFD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("deframer check failed in the following cycle");

`endif

>>> sv/wsdefr_pkg.sv
// ---------------------------------------------------------------------------
// WebSocket deframer package
// Result kinds, opcodes and register map of the deframer.
// ---------------------------------------------------------------------------
package wsdefr_pkg;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_EMPTY = 3'd1,
        KIND_PONG  = 3'd2,
        KIND_CLOSE = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam int unsigned ADDR_W = 3;
    localparam logic        REG_MAX_LENGTH = 1'b0;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

endpackage

>>> sv/websocket_frame_deframer_top.sv
// ---------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received frame bytes and gives out unmasked payload bytes and events.
// ---------------------------------------------------------------------------
// Channel   Dir  Signals                         Contents
// s_*       in   tvalid tready tdata[7:0]        rx_byte
// m_*       out  tvalid tready tdata tuser tlast data, text_frame, frame_length
// apb       in   psel penable pwrite paddr ...   max_length at address 0
//
// One byte per cycle is taken unless stalled; any result shows in the next cycle.
// The parser state and a single result register sit around one level of logic.
// Input is stalled only while a result waits in the output register.
// Reset is asynchronous and active low; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "websocket_frame_deframer_top_assert.svh"

module websocket_frame_deframer_top
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [7:0] data, [8] text_frame,
                                                        // [24:9] frame_length, [31:25] zero
    output logic [2:0]                       m_tuser,   // [2:0] kind
    output logic                             m_tlast,   // last

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wsdefr_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT0,
        PH_EXT1,
        PH_MASK0,
        PH_MASK1,
        PH_MASK2,
        PH_MASK3,
        PH_DATA
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic              has_mask_reg, has_mask_next;
    logic [15:0]       length_reg, length_next;
    logic [7:0]        key_reg [4];
    logic [15:0]       index_reg, index_next;
    logic [15:0]       max_length_reg;

    logic              out_valid_reg, out_valid_next;
    wsdefr_pkg::kind_t out_kind_reg, res_kind;
    logic [7:0]        out_data_reg, res_data;
    logic              out_text_reg, res_text;
    logic              out_last_reg, res_last;
    logic [15:0]       out_length_reg, res_length;
    logic              res_valid;

    logic              accept;
    logic              key_wr;
    logic [1:0]        key_sel;
    logic              is_text;
    logic [6:0]        len7;
    logic [16:0]       index_inc;
    logic              cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[2] == wsdefr_pkg::REG_MAX_LENGTH);
    assign prdata   = (paddr[2] == wsdefr_pkg::REG_MAX_LENGTH)
                      ? {16'd0, max_length_reg} : 32'd0;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_text   = (opcode_reg == wsdefr_pkg::OP_TEXT);
    assign len7      = s_tdata[6:0];
    assign index_inc = {1'b0, index_reg} + 17'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        has_mask_next = has_mask_reg;
        length_next   = length_reg;
        index_next    = index_reg;
        key_wr        = 1'b0;
        key_sel       = 2'd0;
        res_valid     = 1'b0;
        res_kind      = wsdefr_pkg::KIND_DATA;
        res_data      = 8'd0;
        res_text      = 1'b0;
        res_last      = 1'b1;
        res_length    = 16'd0;

        case (phase_reg)
            PH_HDR0:
            begin
                opcode_next = s_tdata[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                has_mask_next = s_tdata[7];
                if (opcode_reg == wsdefr_pkg::OP_CLOSE)
                begin
                    phase_next = PH_HDR0;
                    res_valid  = 1'b1;
                    res_kind   = wsdefr_pkg::KIND_CLOSE;
                end
                else if (opcode_reg == wsdefr_pkg::OP_PING)
                begin
                    phase_next = PH_HDR0;
                    res_valid  = 1'b1;
                    res_kind   = wsdefr_pkg::KIND_PONG;
                end
                else if (len7 == wsdefr_pkg::LEN_EXT16)
                begin
                    phase_next = PH_EXT0;
                end
                else if (len7 == wsdefr_pkg::LEN_EXT64)
                begin
                    phase_next = PH_HDR0;
                    res_valid  = 1'b1;
                    res_kind   = wsdefr_pkg::KIND_ERROR;
                end
                else
                begin
                    length_next = {9'd0, len7};
                    if (s_tdata[7])
                    begin
                        phase_next = PH_MASK0;
                    end
                    else
                    begin
                        index_next = 16'd0;
                        if ({9'd0, len7} > max_length_reg)
                        begin
                            phase_next = PH_HDR0;
                            res_valid  = 1'b1;
                            res_kind   = wsdefr_pkg::KIND_ERROR;
                            res_length = {9'd0, len7};
                        end
                        else if (len7 == 7'd0)
                        begin
                            phase_next = PH_HDR0;
                            res_valid  = 1'b1;
                            res_kind   = wsdefr_pkg::KIND_EMPTY;
                            res_text   = is_text;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_EXT0:
            begin
                length_next = {s_tdata, 8'd0};
                phase_next  = PH_EXT1;
            end
            PH_EXT1, PH_MASK3:
            begin
                if (phase_reg == PH_EXT1)
                begin
                    length_next = {length_reg[15:8], s_tdata};
                end
                else
                begin
                    key_wr  = 1'b1;
                    key_sel = 2'd3;
                end
                if (phase_reg == PH_EXT1 && has_mask_reg)
                begin
                    phase_next = PH_MASK0;
                end
                else
                begin
                    index_next = 16'd0;
                    if (length_next > max_length_reg)
                    begin
                        phase_next = PH_HDR0;
                        res_valid  = 1'b1;
                        res_kind   = wsdefr_pkg::KIND_ERROR;
                        res_length = length_next;
                    end
                    else if (length_next == 16'd0)
                    begin
                        phase_next = PH_HDR0;
                        res_valid  = 1'b1;
                        res_kind   = wsdefr_pkg::KIND_EMPTY;
                        res_text   = is_text;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_MASK0:
            begin
                key_wr     = 1'b1;
                key_sel    = 2'd0;
                phase_next = PH_MASK1;
            end
            PH_MASK1:
            begin
                key_wr     = 1'b1;
                key_sel    = 2'd1;
                phase_next = PH_MASK2;
            end
            PH_MASK2:
            begin
                key_wr     = 1'b1;
                key_sel    = 2'd2;
                phase_next = PH_MASK3;
            end
            PH_DATA:
            begin
                res_valid  = 1'b1;
                res_kind   = wsdefr_pkg::KIND_DATA;
                res_data   = has_mask_reg ? (s_tdata ^ key_reg[index_reg[1:0]]) : s_tdata;
                res_text   = is_text;
                res_length = length_reg;
                res_last   = (index_inc >= {1'b0, length_reg});
                if (res_last)
                begin
                    phase_next = PH_HDR0;
                    index_next = 16'd0;
                end
                else
                begin
                    index_next = index_inc[15:0];
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR0;
            opcode_reg     <= 4'd0;
            has_mask_reg   <= 1'b0;
            length_reg     <= 16'd0;
            index_reg      <= 16'd0;
            key_reg[0]     <= 8'd0;
            key_reg[1]     <= 8'd0;
            key_reg[2]     <= 8'd0;
            key_reg[3]     <= 8'd0;
            max_length_reg <= wsdefr_pkg::MAX_LENGTH_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                max_length_reg <= pwdata[15:0];
            end
            if (accept)
            begin
                phase_reg    <= phase_next;
                opcode_reg   <= opcode_next;
                has_mask_reg <= has_mask_next;
                length_reg   <= length_next;
                index_reg    <= index_next;
                if (key_wr)
                begin
                    key_reg[key_sel] <= s_tdata;
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_kind_reg   <= res_kind;
            out_data_reg   <= res_data;
            out_text_reg   <= res_text;
            out_last_reg   <= res_last;
            out_length_reg <= res_length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_length_reg, out_text_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `WFD_ASSERT_NOW(a_event_is_last, clk, rst_n,
        m_tvalid && (m_tuser != wsdefr_pkg::KIND_DATA), m_tlast)
    `WFD_ASSERT_NOW(a_event_no_data, clk, rst_n,
        m_tvalid && (m_tuser != wsdefr_pkg::KIND_DATA), m_tdata[7:0] == 8'd0)
    `WFD_ASSERT_NOW(a_stall_cause, clk, rst_n,
        !s_tready, m_tvalid && !m_tready)
    `WFD_ASSERT_NOW(a_data_index_bound, clk, rst_n,
        phase_reg == PH_DATA, (length_reg != 16'd0) && (index_reg < length_reg))
    `WFD_ASSERT_NEXT(a_result_follows, clk, rst_n,
        accept && res_valid, m_tvalid)

endmodule

>>> sim/websocket_frame_deframer_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends well-formed frames with random content, broken sequences and noise to
// the deframer, mostly under random stalls on both streams, and at several max_length
// settings. Every accepted request is run through a parser model and each
// result is checked field by field against the oldest expected event.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_top_tb;

    typedef enum logic [3:0] {
        ST_HEAD0 = 4'd0,
        ST_HEAD1 = 4'd1,
        ST_EXT0  = 4'd2,
        ST_EXT1  = 4'd3,
        ST_KEY0  = 4'd4,
        ST_KEY1  = 4'd5,
        ST_KEY2  = 4'd6,
        ST_KEY3  = 4'd7,
        ST_DATA  = 4'd8
    } parse_state_t;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        text_frame;
        logic        last;
        logic [15:0] frame_length;
    } frame_event_t;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_RSVD_A = 4'hA;
    localparam logic [3:0] OP_RSVD_F = 4'hF;

    localparam logic [wsdefr_pkg::ADDR_W-1:0] MAX_LENGTH_ADDR =
        wsdefr_pkg::ADDR_W'(4 * wsdefr_pkg::REG_MAX_LENGTH);

    class frame_event_tracker_t;
        parse_state_t state;
        logic [3:0]   opcode;
        logic         masked;
        logic [15:0]  length;
        logic [7:0]   key [4];
        logic [15:0]  index;
        logic [15:0]  max_length;
        frame_event_t expected_events [$];
        int           errors;

        function new();
            state      = ST_HEAD0;
            opcode     = '0;
            masked     = 1'b0;
            length     = '0;
            index      = '0;
            max_length = wsdefr_pkg::MAX_LENGTH_RESET;
            errors     = 0;
            foreach (key[i])
            begin
                key[i] = '0;
            end
        endfunction

        function void push(logic [2:0] kind, logic [7:0] data, logic text_frame, logic last,
                           logic [15:0] frame_length);
            frame_event_t e;
            e.kind         = kind;
            e.data         = data;
            e.text_frame   = text_frame;
            e.last         = last;
            e.frame_length = frame_length;
            expected_events.push_back(e);
        endfunction

        function void finish_header();
            index = '0;
            if (length > max_length)
            begin
                state = ST_HEAD0;
                push(wsdefr_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, length);
            end
            else if (length == 16'd0)
            begin
                state = ST_HEAD0;
                push(wsdefr_pkg::KIND_EMPTY, 8'h00, opcode == wsdefr_pkg::OP_TEXT, 1'b1,
                     16'd0);
            end
            else
            begin
                state = ST_DATA;
            end
        endfunction

        function void finish_length();
            if (masked)
                state = ST_KEY0;
            else
                finish_header();
        endfunction

        function void note_request(logic [7:0] b);
            logic [7:0] d;
            logic       last;
            case (state)
                ST_HEAD0:
                begin
                    opcode = b[3:0];
                    state  = ST_HEAD1;
                end
                ST_HEAD1:
                begin
                    masked = b[7];
                    if (opcode == wsdefr_pkg::OP_CLOSE)
                    begin
                        state = ST_HEAD0;
                        push(wsdefr_pkg::KIND_CLOSE, 8'h00, 1'b0, 1'b1, 16'd0);
                    end
                    else if (opcode == wsdefr_pkg::OP_PING)
                    begin
                        state = ST_HEAD0;
                        push(wsdefr_pkg::KIND_PONG, 8'h00, 1'b0, 1'b1, 16'd0);
                    end
                    else if (b[6:0] == wsdefr_pkg::LEN_EXT16)
                    begin
                        state = ST_EXT0;
                    end
                    else if (b[6:0] == wsdefr_pkg::LEN_EXT64)
                    begin
                        state = ST_HEAD0;
                        push(wsdefr_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, 16'd0);
                    end
                    else
                    begin
                        length = {9'd0, b[6:0]};
                        finish_length();
                    end
                end
                ST_EXT0:
                begin
                    length = {b, 8'h00};
                    state  = ST_EXT1;
                end
                ST_EXT1:
                begin
                    length[7:0] = b;
                    finish_length();
                end
                ST_KEY0, ST_KEY1, ST_KEY2, ST_KEY3:
                begin
                    key[2'(state - ST_KEY0)] = b;
                    if (state == ST_KEY3)
                        finish_header();
                    else
                        state = parse_state_t'(state + 1);
                end
                ST_DATA:
                begin
                    d     = masked ? (b ^ key[index[1:0]]) : b;
                    last  = ({1'b0, index} + 17'd1) >= {1'b0, length};
                    index = index + 16'd1;
                    if (last)
                    begin
                        state = ST_HEAD0;
                        index = '0;
                    end
                    push(wsdefr_pkg::KIND_DATA, d, opcode == wsdefr_pkg::OP_TEXT, last, length);
                end
                default:
                begin
                    state = ST_HEAD0;
                end
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data, logic text_frame,
                                   logic last, logic [15:0] frame_length);
            frame_event_t e;
            if (expected_events.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending: kind %0d data %02h",
                         $time, kind, data);
                return;
            end
            e = expected_events.pop_front();
            if (e.kind !== kind)
            begin
                errors++;
                $display("%0t: kind: expected %0d, actual %0d", $time, e.kind, kind);
            end
            if (e.data !== data)
            begin
                errors++;
                $display("%0t: data: expected %02h, actual %02h", $time, e.data, data);
            end
            if (e.text_frame !== text_frame)
            begin
                errors++;
                $display("%0t: text_frame: expected %0b, actual %0b",
                         $time, e.text_frame, text_frame);
            end
            if (e.last !== last)
            begin
                errors++;
                $display("%0t: last: expected %0b, actual %0b", $time, e.last, last);
            end
            if (e.frame_length !== frame_length)
            begin
                errors++;
                $display("%0t: frame_length: expected %0d, actual %0d",
                         $time, e.frame_length, frame_length);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [wsdefr_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_event_tracker_t tracker;
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          hold_off_req;
    int unsigned sent_count;

    websocket_frame_deframer_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        tracker.note_request(b);
        sent_count++;
    endtask

    task automatic send_frame(input logic [3:0] op, input bit masked, input logic [15:0] len,
                              input bit ext, input bit long_code);
        logic [6:0] code;
        if (long_code)
            code = wsdefr_pkg::LEN_EXT64;
        else if (ext || len > 16'd125)
            code = wsdefr_pkg::LEN_EXT16;
        else
            code = len[6:0];
        send_byte({4'($urandom), op});
        send_byte({masked, code});
        if (tracker.state == ST_EXT0)
            send_byte(len[15:8]);
        if (tracker.state == ST_EXT1)
            send_byte(len[7:0]);
        while (tracker.state >= ST_KEY0 && tracker.state <= ST_KEY3)
            send_byte(8'($urandom));
        while (tracker.state == ST_DATA)
            send_byte(8'($urandom));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom));
        while (tracker.state != ST_HEAD0)
        begin
            if (tracker.state == ST_EXT0)
                send_byte(8'($urandom_range(0, 1)));
            else
                send_byte(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LENGTH_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.max_length = value;
    endtask

    task automatic send_random_frame();
        int          r;
        logic [3:0]  op;
        logic [15:0] len;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = wsdefr_pkg::OP_TEXT;
        else if (r < 60)
            op = OP_BINARY;
        else if (r < 70)
            op = OP_CONT;
        else if (r < 78)
            op = wsdefr_pkg::OP_CLOSE;
        else if (r < 86)
            op = wsdefr_pkg::OP_PING;
        else
            op = 4'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            len = 16'd0;
        else if (r < 65)
            len = 16'($urandom_range(1, 20));
        else if (r < 85)
            len = 16'($urandom_range(21, 125));
        else if (r < 95 || tracker.max_length > 16'd400)
            len = 16'($urandom_range(126, 400));
        else if ($urandom_range(0, 1) == 0)
            len = tracker.max_length + 16'($urandom_range(0, 1));
        else
            len = 16'($urandom_range(401, 65535));
        send_frame(op, $urandom_range(0, 1), len,
                   len < 16'd126 && $urandom_range(0, 9) == 0, $urandom_range(0, 32) == 0);
    endtask

    initial
    begin : receiver
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap(1'b1) + 1) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata[7:0], m_tdata[8], m_tlast, m_tdata[24:9]);
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("websocket_frame_deframer_top test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] settings [8];
        int unsigned start_count;
        tracker      = new();
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_off_req = 1'b0;
        sent_count   = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(wsdefr_pkg::OP_TEXT, 1'b1, 16'd5, 1'b0, 1'b0);
        send_frame(OP_BINARY, 1'b0, 16'd3, 1'b0, 1'b0);
        send_frame(wsdefr_pkg::OP_TEXT, 1'b0, 16'd0, 1'b0, 1'b0);
        send_frame(OP_BINARY, 1'b1, 16'd0, 1'b0, 1'b0);
        send_frame(wsdefr_pkg::OP_CLOSE, 1'b1, 16'd7, 1'b0, 1'b0);
        send_frame(wsdefr_pkg::OP_PING, 1'b0, 16'd4, 1'b0, 1'b0);
        send_frame(wsdefr_pkg::OP_TEXT, 1'b1, 16'd2, 1'b0, 1'b0);
        send_frame(OP_RSVD_A, 1'b0, 16'd0, 1'b0, 1'b1);
        send_frame(wsdefr_pkg::OP_TEXT, 1'b1, 16'd130, 1'b1, 1'b0);
        send_frame(OP_CONT, 1'b0, 16'd3, 1'b1, 1'b0);
        send_frame(OP_RSVD_F, 1'b1, 16'd125, 1'b0, 1'b0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_frame(wsdefr_pkg::OP_TEXT, 1'b1, 16'd40, 1'b1, 1'b0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        write_max_length(16'd10);
        send_frame(wsdefr_pkg::OP_TEXT, 1'b1, 16'd10, 1'b0, 1'b0);
        send_frame(wsdefr_pkg::OP_TEXT, 1'b0, 16'd11, 1'b0, 1'b0);
        send_frame(OP_BINARY, 1'b1, 16'd11, 1'b0, 1'b0);
        send_frame(wsdefr_pkg::OP_TEXT, 1'b1, 16'hFFFF, 1'b1, 1'b0);
        write_max_length(16'd0);
        send_frame(wsdefr_pkg::OP_TEXT, 1'b1, 16'd0, 1'b0, 1'b0);
        send_frame(OP_BINARY, 1'b0, 16'd1, 1'b0, 1'b0);

        settings[0] = 16'd0;
        settings[1] = 16'd1;
        settings[2] = 16'd20;
        settings[3] = 16'd125;
        settings[4] = 16'd126;
        settings[5] = 16'd300;
        settings[6] = 16'($urandom_range(2, 400));
        settings[7] = 16'hFFFF;
        start_count = sent_count;
        foreach (settings[p])
        begin
            write_max_length(settings[p]);
            tx_idle_en = (p != 2);
            rx_idle_en = (p != 2);
            if (p == 3)
                hold_off_req = 1'b1;
            while (sent_count - start_count < (p + 1) * 900 / 8)
            begin
                if ($urandom_range(0, 99) < 6)
                    send_noise();
                else
                    send_random_frame();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_events.size() == 0)
            $display("websocket_frame_deframer_top test passed");
        else
            $display("websocket_frame_deframer_top test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/wsdefr_pkg.sv
sv/websocket_frame_deframer_top.sv
sim/websocket_frame_deframer_top_tb.sv
